FILE: hw/rtl/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// shared types, command codes and register indexes of the touch position
// averager
// ----------------------------------------------------------------------------
package tpa_pkg;

  // converter command bytes
  localparam logic [7:0] CMD_Z = 8'hB0;
  localparam logic [7:0] CMD_X = 8'hD0;
  localparam logic [7:0] CMD_Y = 8'h90;

  // panel size used by the mirrored orientations
  localparam logic [15:0] SCREEN_WIDTH  = 16'd320;
  localparam logic [15:0] SCREEN_HEIGHT = 16'd480;

  // register indexes
  localparam logic [2:0] REG_PRESSURE_THR = 3'd0;
  localparam logic [2:0] REG_X_THR        = 3'd1;
  localparam logic [2:0] REG_GAIN_X       = 3'd2;
  localparam logic [2:0] REG_OFFSET_X     = 3'd3;
  localparam logic [2:0] REG_GAIN_Y       = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd5;
  localparam logic [2:0] REG_ORIENTATION  = 3'd6;

  // orientation codes
  localparam logic [1:0] ORIENT_0   = 2'd0;
  localparam logic [1:0] ORIENT_90  = 2'd1;
  localparam logic [1:0] ORIENT_180 = 2'd2;

  // gain times average plus offset fits in 49 bits signed
  localparam int unsigned PROD_W = 49;

  typedef enum logic [2:0] {
    PH_Z = 3'b001,
    PH_X = 3'b010,
    PH_Y = 3'b100
  } phase_e;

  // what the calibration stages do with a transaction
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_X    = 2'd1,
    EV_Y    = 2'd2
  } event_e;

  typedef struct packed {
    logic [7:0]  cmd;
    logic        done;
    event_e      kind;
    logic [15:0] avg;
  } acc_stage_t;

  typedef struct packed {
    logic [7:0]               cmd;
    logic                     done;
    event_e                   kind;
    logic signed [PROD_W-1:0] product;
  } scale_stage_t;

  typedef struct packed {
    logic [15:0] pressure_thr;
    logic [15:0] x_thr;
    logic [31:0] gain_x;
    logic [31:0] offset_x;
    logic [31:0] gain_y;
    logic [31:0] offset_y;
    logic [1:0]  orientation;
  } cfg_t;

endpackage

FILE: hw/rtl/tpa_accum.sv
// ----------------------------------------------------------------------------
// tpa_accum
// input register, sample accumulation and measurement phase sequencing
// ----------------------------------------------------------------------------
module tpa_accum #(
  parameter int unsigned AVG_LOG2 = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [15:0]         sample_i,
  input  logic                restart_i,
  input  logic [15:0]         pressure_thr_i,
  input  logic [15:0]         x_thr_i,
  output logic                valid_o,
  input  logic                ready_i,
  output tpa_pkg::acc_stage_t stage_o
);
  import tpa_pkg::*;

  localparam int unsigned ACC_W = 16 + AVG_LOG2;
  localparam int unsigned CNT_W = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
  localparam logic [CNT_W-1:0] CntLast = CNT_W'((1 << AVG_LOG2) - 1);

  logic              in_valid_q;
  logic [15:0]       sample_q;
  logic              restart_q;
  logic              out_valid_q;
  acc_stage_t        stage_q;
  acc_stage_t        stage_d;
  phase_e            phase_q;
  phase_e            phase_d;
  phase_e            phase_cur;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [CNT_W-1:0]  count_base;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  acc_d;
  logic [ACC_W-1:0]  acc_sum;
  logic              complete;
  logic              out_ready;
  logic              step;

  assign out_ready = !out_valid_q || ready_i;
  assign ready_o   = !in_valid_q || out_ready;
  assign step      = in_valid_q && out_ready;

  always_comb begin
    phase_cur  = restart_q ? PH_Z : phase_q;
    count_base = restart_q ? '0 : count_q;
    acc_sum    = (restart_q ? '0 : acc_q) + ACC_W'(sample_q);
    complete   = (count_base == CntLast);

    stage_d.avg  = acc_sum[ACC_W-1:AVG_LOG2];
    stage_d.done = 1'b0;
    stage_d.kind = EV_NONE;
    phase_d      = phase_cur;

    case (phase_cur)
      PH_X: begin
        stage_d.cmd = CMD_X;
        if (complete) begin
          if (stage_d.avg <= x_thr_i) begin
            stage_d.done = 1'b1;
            stage_d.cmd  = CMD_Z;
            phase_d      = PH_Z;
          end else begin
            stage_d.kind = EV_X;
            stage_d.cmd  = CMD_Y;
            phase_d      = PH_Y;
          end
        end
      end
      PH_Y: begin
        stage_d.cmd = CMD_Y;
        if (complete) begin
          stage_d.done = 1'b1;
          stage_d.kind = EV_Y;
          stage_d.cmd  = CMD_Z;
          phase_d      = PH_Z;
        end
      end
      default: begin
        // pressure phase, also any stray code
        stage_d.cmd = CMD_Z;
        phase_d     = PH_Z;
        if (complete) begin
          if (stage_d.avg <= pressure_thr_i) begin
            stage_d.done = 1'b1;
          end else begin
            stage_d.cmd = CMD_X;
            phase_d     = PH_X;
          end
        end
      end
    endcase

    acc_d   = complete ? '0 : acc_sum;
    count_d = complete ? '0 : count_base + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_Z;
      count_q     <= '0;
      acc_q       <= '0;
    end else begin
      if (ready_o) begin
        in_valid_q <= valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        phase_q <= phase_d;
        count_q <= count_d;
        acc_q   <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      sample_q  <= sample_i;
      restart_q <= restart_i;
    end
    if (step) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = out_valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/tpa_scale.sv
// ----------------------------------------------------------------------------
// tpa_scale
// calibration slope multiply of the averaged axis value
// ----------------------------------------------------------------------------
module tpa_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  tpa_pkg::acc_stage_t   stage_i,
  input  logic [31:0]           gain_x_i,
  input  logic [31:0]           gain_y_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output tpa_pkg::scale_stage_t stage_o
);
  import tpa_pkg::*;

  logic                     valid_q;
  scale_stage_t             stage_q;
  scale_stage_t             stage_d;
  logic [31:0]              gain;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    gain            = (stage_i.kind == EV_X) ? gain_x_i : gain_y_i;
    stage_d.cmd     = stage_i.cmd;
    stage_d.done    = stage_i.done;
    stage_d.kind    = stage_i.kind;
    stage_d.product = PROD_W'($signed(gain)) * PROD_W'($signed({1'b0, stage_i.avg}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: hw/rtl/tpa_finish.sv
// ----------------------------------------------------------------------------
// tpa_finish
// offset add, clamp to 16 bits, x hold, rotation and result register
// ----------------------------------------------------------------------------
module tpa_finish (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  tpa_pkg::scale_stage_t stage_i,
  input  logic [31:0]           offset_x_i,
  input  logic [31:0]           offset_y_i,
  input  logic [1:0]            orientation_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [7:0]            next_command_o,
  output logic                  done_res_o,
  output logic                  touched_o,
  output logic [15:0]           x_pos_o,
  output logic [15:0]           y_pos_o
);
  import tpa_pkg::*;

  logic                     valid_q;
  logic [7:0]               cmd_q;
  logic                     done_q;
  logic                     touched_q;
  logic [15:0]              x_pos_q;
  logic [15:0]              y_pos_q;
  logic [15:0]              x_cal_q;
  logic [31:0]              offset;
  logic signed [PROD_W-1:0] v;
  logic [15:0]              cal;
  logic [15:0]              tx;
  logic [15:0]              ty;
  logic [15:0]              mirror_w;
  logic [15:0]              mirror_h;
  logic [15:0]              x_pos_d;
  logic [15:0]              y_pos_d;
  logic                     take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    offset = (stage_i.kind == EV_X) ? offset_x_i : offset_y_i;
    v      = stage_i.product + PROD_W'($signed(offset));
    if (v[PROD_W-1]) begin
      cal = '0;
    end else if (|v[PROD_W-2:32]) begin
      cal = '1;
    end else begin
      cal = v[31:16];
    end

    tx       = x_cal_q;
    ty       = cal;
    // mirrored coordinates stop at zero
    mirror_w = (tx >= SCREEN_WIDTH) ? '0 : SCREEN_WIDTH - tx;
    mirror_h = (ty >= SCREEN_HEIGHT) ? '0 : SCREEN_HEIGHT - ty;

    case (orientation_i)
      ORIENT_0: begin
        x_pos_d = tx;
        y_pos_d = ty;
      end
      ORIENT_90: begin
        x_pos_d = ty;
        y_pos_d = mirror_w;
      end
      ORIENT_180: begin
        x_pos_d = mirror_w;
        y_pos_d = mirror_h;
      end
      default: begin
        x_pos_d = mirror_h;
        y_pos_d = tx;
      end
    endcase
    if (stage_i.kind != EV_Y) begin
      x_pos_d = '0;
      y_pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      x_cal_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take && stage_i.kind == EV_X) begin
        x_cal_q <= cal;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q     <= stage_i.cmd;
      done_q    <= stage_i.done;
      touched_q <= (stage_i.kind == EV_Y);
      x_pos_q   <= x_pos_d;
      y_pos_q   <= y_pos_d;
    end
  end

  assign valid_o        = valid_q;
  assign next_command_o = cmd_q;
  assign done_res_o     = done_q;
  assign touched_o      = touched_q;
  assign x_pos_o        = x_pos_q;
  assign y_pos_o        = y_pos_q;

endmodule

FILE: hw/rtl/touch_position_averager.sv
// ----------------------------------------------------------------------------
// touch_position_averager
// averages raw touch converter samples per axis and turns them into
// calibrated, rotated screen coordinates
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                    payload
// --------  ---  ---------------------------  ---------------------------------
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample_value, tuser: restart
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: cmd, x, y; tuser: done, touched
// apb       in   psel/penable, pready = 1     seven 32-bit registers at 4*i
//
// one transaction per cycle sustained while m_axis_tready stays high; a sample
// passes from the input register through the accumulate, multiply and result
// registers
// the accumulator feedback is a single 16+AVG_LOG2 bit add, so a new sample
// can follow every cycle
// reset returns the phase to pressure, clears count and accumulator and loads
// the register defaults; no clearing pass is needed
// a stalled result register fills the earlier stages before s_axis_tready drops
//
module touch_position_averager #(
  parameter int unsigned AVG_LOG2 = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input samples
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample_value
  input  logic        s_axis_tuser,   // [0] restart
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] next_command, [23:8] x_pos, [39:24] y_pos
  output logic [1:0]  m_axis_tuser,   // [0] done_res, [1] touched
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tpa_pkg::*;

  cfg_t         cfg_q;
  logic         cfg_wr;
  logic [2:0]   reg_idx;

  logic         acc_valid;
  logic         acc_ready;
  acc_stage_t   acc_stage;
  logic         scale_valid;
  logic         scale_ready;
  scale_stage_t scale_stage;

  logic [7:0]   next_command;
  logic         done_res;
  logic         touched;
  logic [15:0]  x_pos;
  logic [15:0]  y_pos;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_thr <= 16'd1280;
      cfg_q.x_thr        <= 16'd1280;
      cfg_q.gain_x       <= 32'hFFFF_FD56;   // -682
      cfg_q.offset_x     <= 32'd21524165;
      cfg_q.gain_y       <= 32'd1042;
      cfg_q.offset_y     <= 32'hFFEB_0305;   // -1375483
      cfg_q.orientation  <= ORIENT_0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PRESSURE_THR: cfg_q.pressure_thr <= pwdata[15:0];
        REG_X_THR:        cfg_q.x_thr        <= pwdata[15:0];
        REG_GAIN_X:       cfg_q.gain_x       <= pwdata;
        REG_OFFSET_X:     cfg_q.offset_x     <= pwdata;
        REG_GAIN_Y:       cfg_q.gain_y       <= pwdata;
        REG_OFFSET_Y:     cfg_q.offset_y     <= pwdata;
        REG_ORIENTATION:  cfg_q.orientation  <= pwdata[1:0];
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PRESSURE_THR: prdata = {16'd0, cfg_q.pressure_thr};
      REG_X_THR:        prdata = {16'd0, cfg_q.x_thr};
      REG_GAIN_X:       prdata = cfg_q.gain_x;
      REG_OFFSET_X:     prdata = cfg_q.offset_x;
      REG_GAIN_Y:       prdata = cfg_q.gain_y;
      REG_OFFSET_Y:     prdata = cfg_q.offset_y;
      REG_ORIENTATION:  prdata = {30'd0, cfg_q.orientation};
      default:          prdata = '0;
    endcase
  end

  // ----------------------------------------------------------------- pipeline
  // stage 1: input register, running sum and phase sequencing
  tpa_accum #(
    .AVG_LOG2(AVG_LOG2)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .sample_i      (s_axis_tdata),
    .restart_i     (s_axis_tuser),
    .pressure_thr_i(cfg_q.pressure_thr),
    .x_thr_i       (cfg_q.x_thr),
    .valid_o       (acc_valid),
    .ready_i       (acc_ready),
    .stage_o       (acc_stage)
  );

  // stage 2: slope multiply for whichever axis just completed
  tpa_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc_valid),
    .ready_o (acc_ready),
    .stage_i (acc_stage),
    .gain_x_i(cfg_q.gain_x),
    .gain_y_i(cfg_q.gain_y),
    .valid_o (scale_valid),
    .ready_i (scale_ready),
    .stage_o (scale_stage)
  );

  // stage 3: offset, clamp, x hold and rotation into the result register;
  // the calibrated x is kept here until the matching y completes
  tpa_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (scale_valid),
    .ready_o       (scale_ready),
    .stage_i       (scale_stage),
    .offset_x_i    (cfg_q.offset_x),
    .offset_y_i    (cfg_q.offset_y),
    .orientation_i (cfg_q.orientation),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .next_command_o(next_command),
    .done_res_o    (done_res),
    .touched_o     (touched),
    .x_pos_o       (x_pos),
    .y_pos_o       (y_pos)
  );

  assign m_axis_tdata = {y_pos, x_pos, next_command};
  assign m_axis_tuser = {touched, done_res};

endmodule

FILE: hw/rtl/tpa_checker.sv
// ----------------------------------------------------------------------------
// tpa_checker
// port level checks of the touch position averager result stream
// ----------------------------------------------------------------------------
module tpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import tpa_pkg::*;

  // a touch is only reported on a finished measurement
  a_touch_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("touched without done");

  // coordinates stay zero unless a touch is reported
  a_no_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[39:8] == 32'd0)
    else $error("coordinates on a result without touch");

  // a finished measurement always restarts with pressure
  a_done_back_to_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == CMD_Z)
    else $error("done without a pressure command next");

  // only the three converter commands appear
  a_cmd_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:0] == CMD_Z || m_axis_tdata[7:0] == CMD_X ||
                      m_axis_tdata[7:0] == CMD_Y)
    else $error("unknown command byte");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                        $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind touch_position_averager tpa_checker u_tpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the touch position averager: samples stream in
// over the input channel while a local touch tracker predicts every result,
// register settings are walked between drained phases over the apb port
// ----------------------------------------------------------------------------
module tb_top;

  import tpa_pkg::*;

  localparam int unsigned AVG_LOG2   = 4;
  localparam logic [2:0]  REG_SPARE  = 3'd7;   // no register behind this index
  localparam logic [1:0]  ORIENT_270 = 2'd3;
  localparam int          N_SETTINGS = 7;
  localparam int          DRAIN_GAP  = 10;     // covers the input, accumulate, multiply and result registers
  localparam int          HOLD_AT    = 600;    // results seen before the long stall
  localparam int          HOLD_LEN   = 60;
  localparam int          REPORT_MAX = 10;
  localparam int          PHASE_ITEMS [N_SETTINGS] = '{300, 350, 300, 150, 300, 300, 300};

  // one result as the block presents it
  typedef struct packed {
    logic [7:0]  cmd;
    logic        done;
    logic        touched;
    logic [15:0] x;
    logic [15:0] y;
  } touch_res_t;

  // one row of the directed sequence
  typedef struct packed {
    logic [15:0] smp;
    logic        restart;
    logic [4:0]  reps;
    logic        typed;    // compare against want instead of the tracker
    touch_res_t  want;
  } plan_row_t;

  localparam touch_res_t WAIT_Z   = '{cmd: CMD_Z, default: '0};
  localparam touch_res_t NO_TOUCH = '{cmd: CMD_Z, done: 1'b1, default: '0};

  localparam cfg_t CFG_RESET = '{
    pressure_thr: 16'd1280,
    x_thr:        16'd1280,
    gain_x:       32'hFFFF_FD56,   // -682
    offset_x:     32'd21524165,
    gain_y:       32'd1042,
    offset_y:     32'hFFEB_0305,   // -1375483
    orientation:  ORIENT_0
  };

  localparam int PLAN_ROWS = 6;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // first sample after reset
    '{smp: 16'h0500, restart: 1'b0, reps: 5'd1,  typed: 1'b1, want: WAIT_Z},
    '{smp: 16'h0500, restart: 1'b0, reps: 5'd14, typed: 1'b1, want: WAIT_Z},
    // pressure average lands exactly on the threshold, so no touch
    '{smp: 16'h0500, restart: 1'b0, reps: 5'd1,  typed: 1'b1, want: NO_TOUCH},
    '{smp: 16'hFFFF, restart: 1'b0, reps: 5'd3,  typed: 1'b1, want: WAIT_Z},
    // restart drops the partial average
    '{smp: 16'h0000, restart: 1'b1, reps: 5'd1,  typed: 1'b1, want: WAIT_Z},
    '{smp: 16'hFFFF, restart: 1'b0, reps: 5'd3,  typed: 1'b0, want: WAIT_Z}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;    // [15:0] sample_value
  logic        s_axis_tuser  = 1'b0;  // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // [7:0] next_command, [23:8] x_pos, [39:24] y_pos
  logic [1:0]  m_axis_tuser;          // [0] done_res, [1] touched
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  // tracker state, mirrors the block's registers and measurement progress
  cfg_t        panel_cfg = CFG_RESET;
  phase_e      trk_phase = PH_Z;
  int unsigned trk_count = 0;
  int unsigned trk_sum   = 0;
  logic [15:0] trk_xcal  = '0;

  touch_res_t  pending [$];

  int  err_count = 0;
  int  n_sent    = 0;
  int  n_checked = 0;
  int  n_touch   = 0;
  int  n_miss    = 0;
  bit  src_quiet = 1'b0;
  bit  snk_quiet = 1'b0;
  bit  tail_calm = 1'b0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  touch_position_averager #(
    .AVG_LOG2(AVG_LOG2)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  initial begin
    #1_000_000;
    $display("timeout with %0d results still outstanding", pending.size());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tracker
  // --------------------------------------------------------------------------

  // q16.16 line, negative clips to zero, integer part saturates at 16 bits
  function automatic logic [15:0] scale_axis(input logic [15:0] avg, input logic [31:0] gain,
                                             input logic [31:0] offset);
    longint g, o, a, v;
    g = $signed(gain);
    o = $signed(offset);
    a = avg;
    v = g * a + o;
    if (v < 0) return '0;
    if ((v >>> 16) > 65535) return 16'hFFFF;
    return v[31:16];
  endfunction

  // screen mirror, clamps at zero instead of wrapping
  function automatic logic [15:0] fold(input logic [15:0] limit, input logic [15:0] v);
    return (v >= limit) ? 16'd0 : limit - v;
  endfunction

  function automatic touch_res_t touch_step(input logic [15:0] smp, input logic restart);
    touch_res_t  r;
    logic [15:0] avg, ty;
    logic        full;
    r     = '0;
    r.cmd = CMD_Z;
    if (restart) begin
      trk_phase = PH_Z;
      trk_count = 0;
      trk_sum   = 0;
    end
    trk_sum   += smp;
    trk_count += 1;
    full = (trk_count >= (1 << AVG_LOG2));
    avg  = 16'(trk_sum >> AVG_LOG2);
    if (full) begin
      trk_count = 0;
      trk_sum   = 0;
    end
    case (trk_phase)
      PH_Z: begin
        if (full) begin
          if (avg <= panel_cfg.pressure_thr) begin
            r.done = 1'b1;
          end else begin
            trk_phase = PH_X;
            r.cmd     = CMD_X;
          end
        end
      end
      PH_X: begin
        r.cmd = CMD_X;
        if (full) begin
          if (avg <= panel_cfg.x_thr) begin
            r.done    = 1'b1;
            trk_phase = PH_Z;
            r.cmd     = CMD_Z;
          end else begin
            trk_xcal  = scale_axis(avg, panel_cfg.gain_x, panel_cfg.offset_x);
            trk_phase = PH_Y;
            r.cmd     = CMD_Y;
          end
        end
      end
      default: begin
        r.cmd = CMD_Y;
        if (full) begin
          ty        = scale_axis(avg, panel_cfg.gain_y, panel_cfg.offset_y);
          trk_phase = PH_Z;
          r.cmd     = CMD_Z;
          r.done    = 1'b1;
          r.touched = 1'b1;
          case (panel_cfg.orientation)
            ORIENT_0: begin
              r.x = trk_xcal;
              r.y = ty;
            end
            ORIENT_90: begin
              r.x = ty;
              r.y = fold(SCREEN_WIDTH, trk_xcal);
            end
            ORIENT_180: begin
              r.x = fold(SCREEN_WIDTH, trk_xcal);
              r.y = fold(SCREEN_HEIGHT, ty);
            end
            default: begin
              r.x = fold(SCREEN_HEIGHT, ty);
              r.y = trk_xcal;
            end
          endcase
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_PRESSURE_THR, REG_X_THR: return 32'h0000_FFFF;
      REG_ORIENTATION:             return 32'h0000_0003;
      default:                     return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] reg_word(input cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_PRESSURE_THR: return {16'd0, c.pressure_thr};
      REG_X_THR:        return {16'd0, c.x_thr};
      REG_GAIN_X:       return c.gain_x;
      REG_OFFSET_X:     return c.offset_x;
      REG_GAIN_Y:       return c.gain_y;
      REG_OFFSET_Y:     return c.offset_y;
      REG_ORIENTATION:  return {30'd0, c.orientation};
      default:          return '0;
    endcase
  endfunction

  // register write as the block sees it; unknown indexes leave everything alone
  function automatic void store_reg(input logic [2:0] idx, input logic [31:0] word);
    case (idx)
      REG_PRESSURE_THR: panel_cfg.pressure_thr = word[15:0];
      REG_X_THR:        panel_cfg.x_thr        = word[15:0];
      REG_GAIN_X:       panel_cfg.gain_x       = word;
      REG_OFFSET_X:     panel_cfg.offset_x     = word;
      REG_GAIN_Y:       panel_cfg.gain_y       = word;
      REG_OFFSET_Y:     panel_cfg.offset_y     = word;
      REG_ORIENTATION:  panel_cfg.orientation  = word[1:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // bookkeeping
  // --------------------------------------------------------------------------

  function automatic void log_fault(input string what);
    err_count++;
    if (err_count <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic void expect_result(input touch_res_t r);
    pending.push_back(r);
    if (r.done) begin
      if (r.touched) n_touch++;
      else n_miss++;
    end
  endfunction

  task automatic check_result(input logic [39:0] d, input logic [1:0] u);
    touch_res_t want, got;
    got.cmd     = d[7:0];
    got.x       = d[23:8];
    got.y       = d[39:24];
    got.done    = u[0];
    got.touched = u[1];
    if (pending.size() == 0) begin
      log_fault($sformatf("result %h/%b arrived with nothing outstanding", d, u));
      return;
    end
    want = pending.pop_front();
    if (got.cmd !== want.cmd)
      log_fault($sformatf("result %0d next_command exp %02h got %02h",
                          n_checked, want.cmd, got.cmd));
    if (got.done !== want.done)
      log_fault($sformatf("result %0d done exp %b got %b", n_checked, want.done, got.done));
    if (got.touched !== want.touched)
      log_fault($sformatf("result %0d touched exp %b got %b",
                          n_checked, want.touched, got.touched));
    if (got.x !== want.x)
      log_fault($sformatf("result %0d x_pos exp %0d got %0d", n_checked, want.x, got.x));
    if (got.y !== want.y)
      log_fault($sformatf("result %0d y_pos exp %0d got %0d", n_checked, want.y, got.y));
    n_checked++;
  endtask

  // --------------------------------------------------------------------------
  // result side: checks each transaction and throttles tready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    logic next_ready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tuser);
        // reroll whether the next stretch has stalls at all
        if (n_checked % 128 == 0) snk_quiet = ($urandom_range(0, 2) == 0);
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        // long back-pressure so the pipe fills and input stalls
        hold_done  = 1'b1;
        hold_left  = HOLD_LEN - 1;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!snk_quiet && !tail_calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // --------------------------------------------------------------------------
  // sample side and register port
  // --------------------------------------------------------------------------

  // offers one sample and returns at the edge that takes it
  task automatic offer_sample(input logic [15:0] smp, input logic restart);
    if (!src_quiet && !tail_calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // setup then access phase, then psel drops back to idle
  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    for (int i = REG_PRESSURE_THR; i <= REG_ORIENTATION; i++) begin
      apb_access(1'b0, 3'(i), '0, rd);
      if (rd !== reg_word(panel_cfg, 3'(i)))
        log_fault($sformatf("register %0d reads %h, exp %h", i, rd,
                            reg_word(panel_cfg, 3'(i))));
    end
  endtask

  // writes every register, optionally with junk above the field width
  task automatic load_settings(input cfg_t want, input bit junk);
    logic [31:0] word, rd;
    for (int i = REG_PRESSURE_THR; i <= REG_ORIENTATION; i++) begin
      word = reg_word(want, 3'(i));
      if (junk) word |= $urandom & ~reg_mask(3'(i));
      apb_access(1'b1, 3'(i), word, rd);
      store_reg(3'(i), word);
    end
    // write to the hole in the map must change nothing
    word = $urandom;
    apb_access(1'b1, REG_SPARE, word, rd);
    store_reg(REG_SPARE, word);
    check_registers();
  endtask

  function automatic cfg_t settings_for(input int p);
    cfg_t c;
    c = CFG_RESET;
    case (p)
      1: c.orientation = ORIENT_90;
      2: begin
        // extremes: everything passes, x saturates high, y clips to zero
        c.pressure_thr = 16'h0000;
        c.x_thr        = 16'h0000;
        c.gain_x       = 32'h7FFF_FFFF;
        c.offset_x     = 32'h8000_0000;
        c.gain_y       = 32'h8000_0000;
        c.offset_y     = 32'h7FFF_FFFF;
        c.orientation  = ORIENT_180;
      end
      3: begin
        // thresholds at the top, no touch can ever be reported
        c.pressure_thr = 16'hFFFF;
        c.x_thr        = 16'hFFFF;
        c.gain_x       = '0;
        c.offset_x     = '0;
        c.gain_y       = '0;
        c.offset_y     = '0;
        c.orientation  = ORIENT_270;
      end
      4: begin
        c.pressure_thr = 16'($urandom);
        c.x_thr        = 16'($urandom);
        c.gain_x       = $urandom;
        c.offset_x     = $urandom;
        c.gain_y       = $urandom;
        c.offset_y     = $urandom;
        c.orientation  = ORIENT_270;
      end
      5: begin
        // panel-like lines that land near the screen
        c.pressure_thr = 16'($urandom_range(0, 4000));
        c.x_thr        = 16'($urandom_range(0, 4000));
        c.gain_x       = $urandom_range(0, 8192) - 32'd4096;
        c.offset_x     = ($urandom & 32'h03FF_FFFF) - 32'h0200_0000;
        c.gain_y       = $urandom_range(0, 8192) - 32'd4096;
        c.offset_y     = ($urandom & 32'h03FF_FFFF) - 32'h0200_0000;
        c.orientation  = 2'($urandom_range(0, 3));
      end
      6: c.orientation = ORIENT_270;
      default: ;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] clip16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // level around which one averaging window is drawn
  function automatic logic [15:0] pick_level(input phase_e ph);
    int thr, r;
    thr = (ph == PH_X) ? int'(panel_cfg.x_thr) : int'(panel_cfg.pressure_thr);
    r   = $urandom_range(0, 9);
    if (r < 6 || (ph == PH_Y && r < 8)) return 16'($urandom);
    if (r < 8) return clip16(thr + int'($urandom_range(0, 80)) - 40);
    return (r == 8) ? 16'h0000 : 16'hFFFF;
  endfunction

  // mostly whole measurements with noisy windows, some restarts and stray samples
  task automatic run_random(input int count);
    logic [15:0] level, smp;
    logic        rs;
    int          jit;
    level = 16'($urandom);
    jit   = 16;
    for (int k = 0; k < count; k++) begin
      if (k % 100 == 0) src_quiet = ($urandom_range(0, 2) == 0);
      rs = ($urandom_range(0, 59) == 0);
      if (rs || trk_count == 0) begin
        level = pick_level(rs ? PH_Z : trk_phase);
        jit   = $urandom_range(0, 64);
      end
      if ($urandom_range(0, 19) == 0) smp = 16'($urandom);
      else smp = clip16(int'(level) + int'($urandom_range(0, 2 * jit)) - jit);
      offer_sample(smp, rs);
      expect_result(touch_step(smp, rs));
    end
  endtask

  task automatic wait_drained();
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    touch_res_t r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values first
    check_registers();

    // directed rows
    for (int i = 0; i < PLAN_ROWS; i++) begin
      for (int n = 0; n < PLAN[i].reps; n++) begin
        offer_sample(PLAN[i].smp, PLAN[i].restart);
        r = touch_step(PLAN[i].smp, PLAN[i].restart);
        expect_result(PLAN[i].typed ? PLAN[i].want : r);
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < N_SETTINGS; p++) begin
      if (p > 0) begin
        wait_drained();
        load_settings(settings_for(p), p >= 2);
      end
      if (p == N_SETTINGS - 1) tail_calm = 1'b1;
      run_random(PHASE_ITEMS[p]);
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();

    $display("%0d samples sent under %0d register settings, %0d results compared",
             n_sent, N_SETTINGS, n_checked);
    $display("measurements closed: %0d with touch, %0d without; %0d mismatches",
             n_touch, n_miss, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
